// File: sv/stt_pkg.sv
`default_nettype none
package stt_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int LENGTH_BITS_DEF = 16;

  // result queue depth; one byte may produce up to three tokens
  localparam int FIFO_DEPTH  = 4;
  localparam int MAX_RESULTS = 3;

  localparam int KIND_W = 5;
  localparam int MODE_W = 3;

  // token kinds
  localparam logic [KIND_W-1:0] K_LBRACE   = 5'd0;
  localparam logic [KIND_W-1:0] K_RBRACE   = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRACKET = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRACKET = 5'd3;
  localparam logic [KIND_W-1:0] K_QUESTION = 5'd4;
  localparam logic [KIND_W-1:0] K_COLON    = 5'd5;
  localparam logic [KIND_W-1:0] K_SEMI     = 5'd6;
  localparam logic [KIND_W-1:0] K_COMMA    = 5'd7;
  localparam logic [KIND_W-1:0] K_EOF      = 5'd8;
  localparam logic [KIND_W-1:0] K_QUOTE    = 5'd9;
  localparam logic [KIND_W-1:0] K_AMPAMP   = 5'd10;
  localparam logic [KIND_W-1:0] K_UNKNOWN  = 5'd11;
  localparam logic [KIND_W-1:0] K_STAR     = 5'd12;
  localparam logic [KIND_W-1:0] K_PLUS     = 5'd14;
  localparam logic [KIND_W-1:0] K_MINUS    = 5'd16;
  localparam logic [KIND_W-1:0] K_SLASH    = 5'd18;
  localparam logic [KIND_W-1:0] K_EXCLAIM  = 5'd20;
  localparam logic [KIND_W-1:0] K_LESS     = 5'd22;
  localparam logic [KIND_W-1:0] K_GREATER  = 5'd24;
  localparam logic [KIND_W-1:0] K_EQUAL    = 5'd26;
  localparam logic [KIND_W-1:0] K_IDENT    = 5'd28;
  localparam logic [KIND_W-1:0] K_NUMBER   = 5'd29;
  localparam logic [KIND_W-1:0] K_NONE     = 5'd0;

  // scan modes
  localparam logic [MODE_W-1:0] M_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] M_AMP     = 3'd1;
  localparam logic [MODE_W-1:0] M_OP      = 3'd2;
  localparam logic [MODE_W-1:0] M_IDENT   = 3'd3;
  localparam logic [MODE_W-1:0] M_NUM     = 3'd4;
  localparam logic [MODE_W-1:0] M_NUM_E   = 3'd5;
  localparam logic [MODE_W-1:0] M_NUM_EXP = 3'd6;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EXCL   = 8'h21;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KIND_W-1:0] pend;
  } scan_ctl_t;

  function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    case (b)
      CH_STAR:  k = K_STAR;
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_SLASH: k = K_SLASH;
      CH_EXCL:  k = K_EXCLAIM;
      CH_LESS:  k = K_LESS;
      CH_GREAT: k = K_GREATER;
      CH_EQ:    k = K_EQUAL;
      default:  k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z], CH_UNDER};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[CH_0:CH_9]};
  endfunction

endpackage
`default_nettype wire

// File: sv/stt_byte_if.sv
`default_nettype none
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

// File: sv/stt_tok_if.sv
`default_nettype none
interface stt_tok_if #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [stt_pkg::KIND_W-1:0] token_kind;
  logic [OFFSET_BITS-1:0]     token_start;
  logic [LENGTH_BITS-1:0]     token_length;
  logic                       last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: sv/stt_lex.sv
`default_nettype none
module stt_lex #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF
) (
  input  wire logic [7:0]                 byte_i,
  input  wire logic [OFFSET_BITS-1:0]     position_i,
  input  wire stt_pkg::scan_ctl_t         ctl_i,
  input  wire logic [OFFSET_BITS-1:0]     run_start_i,
  input  wire logic [LENGTH_BITS-1:0]     run_len_i,
  output      logic [OFFSET_BITS-1:0]     position_o,
  output      stt_pkg::scan_ctl_t         ctl_o,
  output      logic [OFFSET_BITS-1:0]     run_start_o,
  output      logic [LENGTH_BITS-1:0]     run_len_o,
  output      logic [1:0]                 count_o,
  output      logic [stt_pkg::KIND_W-1:0] kind_o  [stt_pkg::MAX_RESULTS],
  output      logic [OFFSET_BITS-1:0]     start_o [stt_pkg::MAX_RESULTS],
  output      logic [LENGTH_BITS-1:0]     len_o   [stt_pkg::MAX_RESULTS]
);

  localparam int SUM_W = ((OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS) + 1;
  localparam logic [LENGTH_BITS-1:0] LEN1 = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN2 = LENGTH_BITS'(2);

  logic [SUM_W-1:0]       end_sum;
  logic [OFFSET_BITS-1:0] end_off;
  logic [LENGTH_BITS:0]   len_p1_sum;
  logic [LENGTH_BITS:0]   len_p2_sum;
  logic [LENGTH_BITS-1:0] len_p1;
  logic [LENGTH_BITS-1:0] len_p2;
  logic [OFFSET_BITS:0]   pos_sum;
  logic                   alnum;
  logic                   numch;
  logic [stt_pkg::KIND_W-1:0] opk;

  // offset just past the pending run, saturating
  assign end_sum = SUM_W'(run_start_i) + SUM_W'(run_len_i);
  assign end_off = (end_sum[SUM_W-1:OFFSET_BITS] != '0) ? '1 : end_sum[OFFSET_BITS-1:0];

  assign len_p1_sum = {1'b0, run_len_i} + (LENGTH_BITS+1)'(1);
  assign len_p2_sum = {1'b0, run_len_i} + (LENGTH_BITS+1)'(2);
  assign len_p1     = len_p1_sum[LENGTH_BITS] ? '1 : len_p1_sum[LENGTH_BITS-1:0];
  assign len_p2     = len_p2_sum[LENGTH_BITS] ? '1 : len_p2_sum[LENGTH_BITS-1:0];

  assign pos_sum = {1'b0, position_i} + (OFFSET_BITS+1)'(1);

  assign alnum = stt_pkg::is_alpha(byte_i) || stt_pkg::is_digit(byte_i);
  assign numch = stt_pkg::is_digit(byte_i) || (byte_i == stt_pkg::CH_DOT);
  assign opk   = stt_pkg::op_kind(byte_i);

  always_comb begin
    logic [1:0] n;
    logic       taken;
    n           = 2'd0;
    taken       = 1'b0;
    ctl_o       = ctl_i;
    run_start_o = run_start_i;
    run_len_o   = run_len_i;
    position_o  = pos_sum[OFFSET_BITS] ? '1 : pos_sum[OFFSET_BITS-1:0];
    for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
      kind_o[i]  = stt_pkg::K_NONE;
      start_o[i] = '0;
      len_o[i]   = '0;
    end

    if (byte_i == stt_pkg::CH_NUL) begin
      // close the pending token, then end of file
      case (ctl_i.mode)
        stt_pkg::M_AMP: begin
          kind_o[n] = stt_pkg::K_UNKNOWN; start_o[n] = run_start_i; len_o[n] = LEN1;
          n = n + 2'd1;
        end
        stt_pkg::M_OP: begin
          kind_o[n] = ctl_i.pend; start_o[n] = run_start_i; len_o[n] = LEN1;
          n = n + 2'd1;
        end
        stt_pkg::M_IDENT: begin
          kind_o[n] = stt_pkg::K_IDENT; start_o[n] = run_start_i; len_o[n] = run_len_i;
          n = n + 2'd1;
        end
        stt_pkg::M_NUM, stt_pkg::M_NUM_EXP: begin
          kind_o[n] = stt_pkg::K_NUMBER; start_o[n] = run_start_i; len_o[n] = run_len_i;
          n = n + 2'd1;
        end
        stt_pkg::M_NUM_E: begin
          kind_o[n] = stt_pkg::K_NUMBER; start_o[n] = run_start_i; len_o[n] = run_len_i;
          n = n + 2'd1;
          kind_o[n] = stt_pkg::K_IDENT; start_o[n] = end_off; len_o[n] = LEN1;
          n = n + 2'd1;
        end
        default: ;
      endcase
      kind_o[n]  = stt_pkg::K_EOF; start_o[n] = position_i; len_o[n] = LEN1;
      n          = n + 2'd1;
      position_o  = '0;
      ctl_o.mode  = stt_pkg::M_IDLE;
      ctl_o.pend  = stt_pkg::K_NONE;
      run_start_o = '0;
      run_len_o   = '0;
    end else begin
      case (ctl_i.mode)
        stt_pkg::M_AMP: begin
          kind_o[n]  = (byte_i == stt_pkg::CH_AMP) ? stt_pkg::K_AMPAMP : stt_pkg::K_UNKNOWN;
          start_o[n] = run_start_i; len_o[n] = LEN2;
          n          = n + 2'd1;
          ctl_o.mode = stt_pkg::M_IDLE;
          taken      = 1'b1;
        end
        stt_pkg::M_OP: begin
          if (byte_i == stt_pkg::CH_EQ) begin
            kind_o[n] = ctl_i.pend + 5'd1; start_o[n] = run_start_i; len_o[n] = LEN2;
            taken     = 1'b1;
          end else begin
            kind_o[n] = ctl_i.pend; start_o[n] = run_start_i; len_o[n] = LEN1;
          end
          n          = n + 2'd1;
          ctl_o.mode = stt_pkg::M_IDLE;
        end
        stt_pkg::M_IDENT: begin
          if (alnum) begin
            run_len_o = len_p1;
            taken     = 1'b1;
          end else begin
            kind_o[n] = stt_pkg::K_IDENT; start_o[n] = run_start_i; len_o[n] = run_len_i;
            n          = n + 2'd1;
            ctl_o.mode = stt_pkg::M_IDLE;
          end
        end
        stt_pkg::M_NUM: begin
          if (numch) begin
            run_len_o = len_p1;
            taken     = 1'b1;
          end else if (byte_i == stt_pkg::CH_LOW_E || byte_i == stt_pkg::CH_UP_E) begin
            ctl_o.mode = stt_pkg::M_NUM_E;
            taken      = 1'b1;
          end else begin
            kind_o[n] = stt_pkg::K_NUMBER; start_o[n] = run_start_i; len_o[n] = run_len_i;
            n          = n + 2'd1;
            ctl_o.mode = stt_pkg::M_IDLE;
          end
        end
        stt_pkg::M_NUM_E: begin
          if (byte_i == stt_pkg::CH_PLUS || byte_i == stt_pkg::CH_MINUS) begin
            run_len_o  = len_p2;
            ctl_o.mode = stt_pkg::M_NUM_EXP;
            taken      = 1'b1;
          end else begin
            // broken exponent: the number ends before the e, the e starts a name
            kind_o[n] = stt_pkg::K_NUMBER; start_o[n] = run_start_i; len_o[n] = run_len_i;
            n           = n + 2'd1;
            run_start_o = end_off;
            if (alnum) begin
              run_len_o  = LEN2;
              ctl_o.mode = stt_pkg::M_IDENT;
              taken      = 1'b1;
            end else begin
              run_len_o = LEN1;
              kind_o[n] = stt_pkg::K_IDENT; start_o[n] = end_off; len_o[n] = LEN1;
              n          = n + 2'd1;
              ctl_o.mode = stt_pkg::M_IDLE;
            end
          end
        end
        stt_pkg::M_NUM_EXP: begin
          if (numch) begin
            run_len_o = len_p1;
            taken     = 1'b1;
          end else begin
            kind_o[n] = stt_pkg::K_NUMBER; start_o[n] = run_start_i; len_o[n] = run_len_i;
            n          = n + 2'd1;
            ctl_o.mode = stt_pkg::M_IDLE;
          end
        end
        default: ctl_o.mode = stt_pkg::M_IDLE;
      endcase

      // byte not absorbed: it opens a new token
      if (!taken) begin
        case (byte_i)
          stt_pkg::CH_LBRACE: begin
            kind_o[n] = stt_pkg::K_LBRACE; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          stt_pkg::CH_RBRACE: begin
            kind_o[n] = stt_pkg::K_RBRACE; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          stt_pkg::CH_LBRACK: begin
            kind_o[n] = stt_pkg::K_LBRACKET; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          stt_pkg::CH_RBRACK: begin
            kind_o[n] = stt_pkg::K_RBRACKET; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          stt_pkg::CH_QUEST: begin
            kind_o[n] = stt_pkg::K_QUESTION; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          stt_pkg::CH_COLON: begin
            kind_o[n] = stt_pkg::K_COLON; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          stt_pkg::CH_SEMI: begin
            kind_o[n] = stt_pkg::K_SEMI; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          stt_pkg::CH_COMMA: begin
            kind_o[n] = stt_pkg::K_COMMA; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          stt_pkg::CH_DQUOTE: begin
            kind_o[n] = stt_pkg::K_QUOTE; start_o[n] = position_i; len_o[n] = LEN1;
            n = n + 2'd1;
          end
          default: begin
            run_start_o = position_i;
            run_len_o   = LEN1;
            if (byte_i == stt_pkg::CH_AMP) begin
              ctl_o.mode = stt_pkg::M_AMP;
            end else if (opk != stt_pkg::K_NONE) begin
              ctl_o.mode = stt_pkg::M_OP;
              ctl_o.pend = opk;
            end else if (stt_pkg::is_alpha(byte_i)) begin
              ctl_o.mode = stt_pkg::M_IDENT;
            end else if (stt_pkg::is_digit(byte_i)) begin
              ctl_o.mode = stt_pkg::M_NUM;
            end else begin
              run_len_o = '0;
              kind_o[n] = stt_pkg::K_UNKNOWN; start_o[n] = position_i; len_o[n] = LEN1;
              n = n + 2'd1;
            end
          end
        endcase
      end
    end
    count_o = n;
  end

endmodule
`default_nettype wire

// File: sv/source_text_tokenizer.sv
// Channel  Interface    Dir  Word
// in_ch    stt_byte_if  in   byte_in: one source byte, zero ends the buffer
// out_ch   stt_tok_if   out  token_kind, token_start, token_length, last_of_run
//
// Each accepted byte is held in the input register, then is lexed in one
// pass and its zero to three tokens drop into a four-word result queue.
// Sustained rate is one byte per cycle; every byte waits in the input register
// while the queue holds more than one word, so multi-token bytes slow the stream.
// The output side drains one token per cycle while the receiver is ready, straight from the queue head.
// Reset (synchronous, rst_n low) clears the offset, the scan state and the queue.
// A stalled output keeps its word; the input keeps taking bytes while there is room.
`default_nettype none
module source_text_tokenizer #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  stt_byte_if.sink   in_ch,
  stt_tok_if.source  out_ch
);

  localparam int PTR_W = $clog2(stt_pkg::FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam int NR    = stt_pkg::MAX_RESULTS;

  // input register
  logic [7:0] byte_r;
  logic       in_vld_r;

  // scan state
  logic [OFFSET_BITS-1:0] position_r;
  stt_pkg::scan_ctl_t     ctl_r;
  logic [OFFSET_BITS-1:0] run_start_r;
  logic [LENGTH_BITS-1:0] run_len_r;

  logic [OFFSET_BITS-1:0] position_nxt;
  stt_pkg::scan_ctl_t     ctl_nxt;
  logic [OFFSET_BITS-1:0] run_start_nxt;
  logic [LENGTH_BITS-1:0] run_len_nxt;

  logic [1:0]                 res_cnt;
  logic [stt_pkg::KIND_W-1:0] res_kind  [NR];
  logic [OFFSET_BITS-1:0]     res_start [NR];
  logic [LENGTH_BITS-1:0]     res_len   [NR];

  // result queue
  logic [stt_pkg::KIND_W-1:0] q_kind_r  [stt_pkg::FIFO_DEPTH];
  logic [OFFSET_BITS-1:0]     q_start_r [stt_pkg::FIFO_DEPTH];
  logic [LENGTH_BITS-1:0]     q_len_r   [stt_pkg::FIFO_DEPTH];
  logic                       q_last_r  [stt_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r;
  logic [PTR_W-1:0]           rd_ptr_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;

  logic fire;
  logic pop;
  logic in_take;

  // lex the registered byte only when the queue can hold the worst case
  assign fire    = in_vld_r && (count_r <= CNT_W'(stt_pkg::FIFO_DEPTH - NR));
  assign in_ch.ready = !in_vld_r || fire;
  assign in_take = in_ch.valid && in_ch.ready;
  assign pop     = out_ch.valid && out_ch.ready;

  stt_lex #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_lex (
    .byte_i      (byte_r),
    .position_i  (position_r),
    .ctl_i       (ctl_r),
    .run_start_i (run_start_r),
    .run_len_i   (run_len_r),
    .position_o  (position_nxt),
    .ctl_o       (ctl_nxt),
    .run_start_o (run_start_nxt),
    .run_len_o   (run_len_nxt),
    .count_o     (res_cnt),
    .kind_o      (res_kind),
    .start_o     (res_start),
    .len_o       (res_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  // payload: load only on accept
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_ch.byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      ctl_r.mode  <= stt_pkg::M_IDLE;
      ctl_r.pend  <= stt_pkg::K_NONE;
      run_start_r <= '0;
      run_len_r   <= '0;
    end else if (fire) begin
      position_r  <= position_nxt;
      ctl_r       <= ctl_nxt;
      run_start_r <= run_start_nxt;
      run_len_r   <= run_len_nxt;
    end
  end

  // push this byte's tokens in order; the last one carries last_of_run
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < NR; i++) begin
        if (2'(i) < res_cnt) begin
          q_kind_r[PTR_W'(wr_ptr_r + PTR_W'(i))]  <= res_kind[i];
          q_start_r[PTR_W'(wr_ptr_r + PTR_W'(i))] <= res_start[i];
          q_len_r[PTR_W'(wr_ptr_r + PTR_W'(i))]   <= res_len[i];
          q_last_r[PTR_W'(wr_ptr_r + PTR_W'(i))]  <= (2'(i) == res_cnt - 2'd1);
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (fire) begin
      count_nxt = count_nxt + CNT_W'(res_cnt);
    end
    if (pop) begin
      count_nxt = count_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        wr_ptr_r <= PTR_W'(wr_ptr_r + PTR_W'(res_cnt));
      end
      if (pop) begin
        rd_ptr_r <= PTR_W'(rd_ptr_r + PTR_W'(1));
      end
    end
  end

  assign out_ch.valid        = (count_r != '0);
  assign out_ch.token_kind   = q_kind_r[rd_ptr_r];
  assign out_ch.token_start  = q_start_r[rd_ptr_r];
  assign out_ch.token_length = q_len_r[rd_ptr_r];
  assign out_ch.last_of_run  = q_last_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: sv/stt_chk.sv
`default_nettype none
module stt_chk #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [stt_pkg::KIND_W-1:0] out_kind,
  input wire logic [OFFSET_BITS-1:0]     out_start,
  input wire logic [LENGTH_BITS-1:0]     out_length,
  input wire logic                       out_last
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_start)
      && $stable(out_length) && $stable(out_last))
    else $error("stalled token changed");

  // nothing left over after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token valid after reset");

  // end of file closes the byte's run with one byte
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == stt_pkg::K_EOF |-> out_last && out_length == LENGTH_BITS'(1))
    else $error("end of file token malformed");

  // tokens always span at least one byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length != '0)
    else $error("zero length token");

endmodule

bind source_text_tokenizer stt_chk #(
  .OFFSET_BITS (OFFSET_BITS),
  .LENGTH_BITS (LENGTH_BITS)
) u_stt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.token_kind),
  .out_start  (out_ch.token_start),
  .out_length (out_ch.token_length),
  .out_last   (out_ch.last_of_run)
);
`default_nettype wire

// File: tb/source_text_tokenizer_tb.sv
module source_text_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int OFF_W = OFFSET_BITS_DEF;
  localparam int LEN_W = LENGTH_BITS_DEF;
  localparam logic [OFF_W-1:0] OFF_TOP = '1;
  localparam logic [LEN_W-1:0] LEN_TOP = '1;
  localparam logic [OFF_W-1:0] OFF_ONE = OFF_W'(1);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);

  localparam logic [7:0] SPACE_CH = 8'h20;

  // Random stimulus target and the single long receiver hold-off.
  localparam int RANDOM_BYTES = 372;
  localparam int LONG_HOLD    = 200;
  // Quiet cycles tolerated: sender gap + receiver gap + long hold, several times over.
  localparam int QUIET_LIMIT  = 3000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [7:0]        ch;
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  len;
  } opening_row_t;

  logic clk;
  logic rst_n;

  stt_byte_if byte_if ();
  stt_tok_if #(.OFFSET_BITS(OFF_W), .LENGTH_BITS(LEN_W)) tok_if ();

  source_text_tokenizer #(
    .OFFSET_BITS(OFF_W),
    .LENGTH_BITS(LEN_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_if),
    .out_ch (tok_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Tokens the block still owes, oldest first.
  token_t due_tokens[$];
  // Tokens caused by the byte just accepted.
  token_t step_toks[$];
  token_t head_tok;
  logic [7:0] lexeme_buf[$];

  int errors = 0;
  int quiet_cycles = 0;
  logic send_idle = 1'b1;
  logic take_idle = 1'b1;
  logic long_hold_req = 1'b0;

  // Lexer state mirrored from the block's point of view.
  logic [OFF_W-1:0]  lx_pos;
  logic [OFF_W-1:0]  lx_run_start;
  logic [LEN_W-1:0]  lx_run_len;
  logic [MODE_W-1:0] lx_mode;
  logic [KIND_W-1:0] lx_pend;

  // Opening table: every mode, each corner of the lexer.
  // Typed rows carry the single token that is obvious from the byte alone.
  opening_row_t opening_rows [27] = '{
    '{CH_LBRACE, 1'b1, K_LBRACE,  24'd0,  16'd1},  // first token after reset
    '{CH_LOW_A,  1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_UNDER,  1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_9,      1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_EQ,     1'b0, K_NONE,    24'd0,  16'd0},  // closes identifier, opens '='
    '{CH_EQ,     1'b0, K_NONE,    24'd0,  16'd0},  // pairs into '=='
    '{CH_AMP,    1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_AMP,    1'b1, K_AMPAMP,  24'd6,  16'd2},
    '{CH_AMP,    1'b0, K_NONE,    24'd0,  16'd0},
    '{8'hFF,     1'b1, K_UNKNOWN, 24'd8,  16'd2},  // ampersand swallows any byte
    '{CH_0,      1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_DOT,    1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_LOW_E,  1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_MINUS,  1'b0, K_NONE,    24'd0,  16'd0},  // signed exponent
    '{CH_9,      1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_RBRACK, 1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_9,      1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_UP_E,   1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_SEMI,   1'b0, K_NONE,    24'd0,  16'd0},  // broken exponent: three tokens
    '{CH_AMP,    1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_NUL,    1'b0, K_NONE,    24'd0,  16'd0},  // lone ampersand at end of buffer
    '{CH_EXCL,   1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_NUL,    1'b0, K_NONE,    24'd0,  16'd0},  // pending operator at end of buffer
    '{CH_NUL,    1'b1, K_EOF,     24'd0,  16'd1},  // offset back at zero
    '{CH_0,      1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_LOW_E,  1'b0, K_NONE,    24'd0,  16'd0},
    '{CH_NUL,    1'b0, K_NONE,    24'd0,  16'd0}   // dangling 'e' flushed at end
  };

  function automatic logic [OFF_W-1:0] off_add(input logic [OFF_W-1:0] a,
                                                input logic [OFF_W-1:0] b);
    logic [OFF_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OFF_W] ? OFF_TOP : s[OFF_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? LEN_TOP : s[LEN_W-1:0];
  endfunction

  function automatic logic letter_ch(input logic [7:0] b);
    return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
           b == CH_UNDER;
  endfunction

  function automatic logic digit_ch(input logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic logic numeral_ch(input logic [7:0] b);
    return digit_ch(b) || b == CH_DOT;
  endfunction

  function automatic logic [KIND_W-1:0] op_code_of(input logic [7:0] b);
    case (b)
      CH_STAR:  return K_STAR;
      CH_PLUS:  return K_PLUS;
      CH_MINUS: return K_MINUS;
      CH_SLASH: return K_SLASH;
      CH_EXCL:  return K_EXCLAIM;
      CH_LESS:  return K_LESS;
      CH_GREAT: return K_GREATER;
      CH_EQ:    return K_EQUAL;
      default:  return K_NONE;
    endcase
  endfunction

  function automatic void push_tok(input logic [KIND_W-1:0] k, input logic [OFF_W-1:0] s,
                                   input logic [LEN_W-1:0] n);
    token_t t;
    t = '{kind: k, start: s, len: n, last: 1'b0};
    step_toks = {step_toks, t};
  endfunction

  function automatic void lex_clear();
    lx_pos       = '0;
    lx_run_start = '0;
    lx_run_len   = '0;
    lx_mode      = M_IDLE;
    lx_pend      = K_NONE;
  endfunction

  // A byte that opens a new token at the current offset.
  function automatic void lex_start(input logic [7:0] b);
    logic [KIND_W-1:0] op;
    op = op_code_of(b);
    case (b)
      CH_LBRACE: push_tok(K_LBRACE,   lx_pos, LEN_ONE);
      CH_RBRACE: push_tok(K_RBRACE,   lx_pos, LEN_ONE);
      CH_LBRACK: push_tok(K_LBRACKET, lx_pos, LEN_ONE);
      CH_RBRACK: push_tok(K_RBRACKET, lx_pos, LEN_ONE);
      CH_QUEST:  push_tok(K_QUESTION, lx_pos, LEN_ONE);
      CH_COLON:  push_tok(K_COLON,    lx_pos, LEN_ONE);
      CH_SEMI:   push_tok(K_SEMI,     lx_pos, LEN_ONE);
      CH_COMMA:  push_tok(K_COMMA,    lx_pos, LEN_ONE);
      CH_DQUOTE: push_tok(K_QUOTE,    lx_pos, LEN_ONE);
      default: begin
        lx_run_start = lx_pos;
        lx_run_len   = LEN_ONE;
        if (b == CH_AMP) begin
          lx_mode = M_AMP;
        end else if (op != K_NONE) begin
          lx_mode = M_OP;
          lx_pend = op;
        end else if (letter_ch(b)) begin
          lx_mode = M_IDENT;
        end else if (digit_ch(b)) begin
          lx_mode = M_NUM;
        end else begin
          lx_run_len = '0;
          push_tok(K_UNKNOWN, lx_pos, LEN_ONE);
        end
      end
    endcase
  endfunction

  // Close whatever run is open ahead of a zero byte.
  function automatic void lex_flush();
    case (lx_mode)
      M_AMP:               push_tok(K_UNKNOWN, lx_run_start, LEN_ONE);
      M_OP:                push_tok(lx_pend, lx_run_start, LEN_ONE);
      M_IDENT:             push_tok(K_IDENT, lx_run_start, lx_run_len);
      M_NUM, M_NUM_EXP:    push_tok(K_NUMBER, lx_run_start, lx_run_len);
      M_NUM_E: begin
        push_tok(K_NUMBER, lx_run_start, lx_run_len);
        push_tok(K_IDENT, off_add(lx_run_start, OFF_W'(lx_run_len)), LEN_ONE);
      end
      default: ;
    endcase
  endfunction

  // Work out the tokens one accepted byte causes and advance the mirror state.
  function automatic void lex_byte(input logic [7:0] b);
    logic taken;
    taken = 1'b0;
    step_toks.delete();
    if (b == CH_NUL) begin
      lex_flush();
      push_tok(K_EOF, lx_pos, LEN_ONE);
      lex_clear();
    end else begin
      case (lx_mode)
        M_AMP: begin
          push_tok((b == CH_AMP) ? K_AMPAMP : K_UNKNOWN, lx_run_start, LEN_TWO);
          lx_mode = M_IDLE;
          taken   = 1'b1;
        end
        M_OP: begin
          if (b == CH_EQ) begin
            push_tok(lx_pend + 1'b1, lx_run_start, LEN_TWO);
            taken = 1'b1;
          end else begin
            push_tok(lx_pend, lx_run_start, LEN_ONE);
          end
          lx_mode = M_IDLE;
        end
        M_IDENT: begin
          if (letter_ch(b) || digit_ch(b)) begin
            lx_run_len = len_add(lx_run_len, LEN_ONE);
            taken      = 1'b1;
          end else begin
            push_tok(K_IDENT, lx_run_start, lx_run_len);
            lx_mode = M_IDLE;
          end
        end
        M_NUM: begin
          if (numeral_ch(b)) begin
            lx_run_len = len_add(lx_run_len, LEN_ONE);
            taken      = 1'b1;
          end else if (b == CH_LOW_E || b == CH_UP_E) begin
            lx_mode = M_NUM_E;
            taken   = 1'b1;
          end else begin
            push_tok(K_NUMBER, lx_run_start, lx_run_len);
            lx_mode = M_IDLE;
          end
        end
        M_NUM_E: begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            lx_run_len = len_add(lx_run_len, LEN_TWO);
            lx_mode    = M_NUM_EXP;
            taken      = 1'b1;
          end else begin
            // no sign: the number stops before the 'e', which starts an identifier
            push_tok(K_NUMBER, lx_run_start, lx_run_len);
            lx_run_start = off_add(lx_run_start, OFF_W'(lx_run_len));
            lx_run_len   = LEN_ONE;
            if (letter_ch(b) || digit_ch(b)) begin
              lx_run_len = LEN_TWO;
              lx_mode    = M_IDENT;
              taken      = 1'b1;
            end else begin
              push_tok(K_IDENT, lx_run_start, LEN_ONE);
              lx_mode = M_IDLE;
            end
          end
        end
        M_NUM_EXP: begin
          if (numeral_ch(b)) begin
            lx_run_len = len_add(lx_run_len, LEN_ONE);
            taken      = 1'b1;
          end else begin
            push_tok(K_NUMBER, lx_run_start, lx_run_len);
            lx_mode = M_IDLE;
          end
        end
        default: lx_mode = M_IDLE;
      endcase
      if (!taken) lex_start(b);
      lx_pos = off_add(lx_pos, OFF_ONE);
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return CH_LOW_A + 8'(r);
    if (r < 52) return CH_UP_A + 8'(r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] ops [8];
    ops = '{CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH, CH_EXCL, CH_LESS, CH_GREAT, CH_EQ};
    return ops[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] pick_punct();
    logic [7:0] marks [9];
    marks = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_QUEST, CH_COLON, CH_SEMI,
              CH_COMMA, CH_DQUOTE};
    return marks[$urandom_range(0, 8)];
  endfunction

  // Append one byte to the lexeme under construction.
  function automatic void add_ch(input logic [7:0] b);
    lexeme_buf = {lexeme_buf, b};
  endfunction

  // Build one lexeme, mostly well formed, into lexeme_buf.
  function automatic void build_lexeme();
    int r;
    lexeme_buf.delete();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        add_ch(pick_alpha());
        repeat ($urandom_range(0, 6))
          add_ch(($urandom_range(0, 2) == 0) ? pick_digit() : pick_alpha());
      end
      4, 5, 6: begin
        add_ch(pick_digit());
        repeat ($urandom_range(0, 4))
          add_ch(($urandom_range(0, 3) == 0) ? CH_DOT : pick_digit());
        if ($urandom_range(0, 2) == 0) begin
          add_ch($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
          r = $urandom_range(0, 5);
          if (r < 4) add_ch((r < 2) ? CH_PLUS : CH_MINUS);
          else if (r == 4) add_ch(pick_alpha());
          else add_ch(8'($urandom_range(1, 255)));
          repeat ($urandom_range(0, 3))
            add_ch(($urandom_range(0, 3) == 0) ? CH_DOT : pick_digit());
        end
      end
      7, 8, 9: begin
        add_ch(pick_operator());
        if ($urandom_range(0, 1)) add_ch(CH_EQ);
      end
      10: begin
        add_ch(CH_AMP);
        add_ch($urandom_range(0, 1) ? CH_AMP : 8'($urandom_range(1, 255)));
      end
      11, 12:  add_ch(pick_punct());
      13, 14:  add_ch(SPACE_CH);
      15, 16:  add_ch(8'($urandom_range(1, 255)));
      17:      add_ch(CH_NUL);
      18:      add_ch(8'($urandom_range(0, 255)));
      default: begin
        // number running straight into an identifier
        add_ch(pick_digit());
        add_ch(pick_alpha());
      end
    endcase
  endfunction

  // Offer one byte after an optional gap, hold it until taken, then record what it owes.
  // Hold valid high across back-to-back words so it is never dropped and raised in one step.
  task automatic offer_byte(input logic [7:0] b, input int gap, input logic typed,
                            input token_t fixed);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.byte_in <= b;
    do @(posedge clk); while (!byte_if.ready);
    lex_byte(b);
    if (typed) due_tokens = {due_tokens, fixed};
    else due_tokens = {due_tokens, step_toks};
  endtask

  initial begin : stimulus
    token_t fixed;
    token_t none_tok;
    int sent;
    none_tok = '0;
    rst_n = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.byte_in = 8'h00;
    lex_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the opening table.
    foreach (opening_rows[i]) begin
      fixed = '{kind: opening_rows[i].kind, start: opening_rows[i].start,
                len: opening_rows[i].len, last: 1'b1};
      offer_byte(opening_rows[i].ch, $urandom_range(0, 16), opening_rows[i].typed, fixed);
    end

    // Random lexemes; open with a long receiver hold-off against a busy sender.
    long_hold_req = 1'b1;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_lexeme();
      foreach (lexeme_buf[j]) begin
        // redraw the idling mix every 40 words; roughly one stretch in four runs flat out
        if (sent % 40 == 0 && sent > 0) begin
          send_idle = ($urandom_range(0, 3) != 0);
          take_idle = ($urandom_range(0, 3) != 0);
        end
        offer_byte(lexeme_buf[j], send_idle ? $urandom_range(0, 16) : 0, 1'b0, none_tok);
        sent++;
      end
    end
    byte_if.valid <= 1'b0;

    // Drain, then watch for any stray word before finishing.
    while (due_tokens.size() != 0) @(posedge clk);
    take_idle = 1'b0;
    repeat (20) @(posedge clk);
    if (errors == 0) $display("source_text_tokenizer_tb: PASS");
    else $display("source_text_tokenizer_tb: FAIL");
    $finish;
  end

  // Token receiver: stall a random number of cycles before each word, or hold off once
  // for a long stretch while the sender keeps pushing.
  initial begin : token_sink
    int wait_n;
    tok_if.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        wait_n = LONG_HOLD;
      end else begin
        wait_n = take_idle ? $urandom_range(0, 16) : 0;
      end
      if (wait_n > 0) begin
        tok_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      tok_if.ready <= 1'b1;
      do @(posedge clk); while (!tok_if.valid || !tok_if.ready);
    end
  end

  // Compare each delivered word with the oldest token owed.
  always @(posedge clk) begin
    if (rst_n && tok_if.valid && tok_if.ready) begin
      if (due_tokens.size() == 0) begin
        $error("unexpected token: kind %0d start %0d length %0d", tok_if.token_kind,
               tok_if.token_start, tok_if.token_length);
        errors++;
      end else begin
        head_tok = due_tokens.pop_front();
        if (tok_if.token_kind !== head_tok.kind) begin
          $error("token_kind: expected %0d, got %0d", head_tok.kind, tok_if.token_kind);
          errors++;
        end
        if (tok_if.token_start !== head_tok.start) begin
          $error("token_start: expected %0d, got %0d", head_tok.start, tok_if.token_start);
          errors++;
        end
        if (tok_if.token_length !== head_tok.len) begin
          $error("token_length: expected %0d, got %0d", head_tok.len, tok_if.token_length);
          errors++;
        end
        if (tok_if.last_of_run !== head_tok.last) begin
          $error("last_of_run: expected %0d, got %0d", head_tok.last, tok_if.last_of_run);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (byte_if.valid && byte_if.ready) || (tok_if.valid && tok_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("source_text_tokenizer_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: filelist.f
sv/stt_pkg.sv
sv/stt_byte_if.sv
sv/stt_tok_if.sv
sv/stt_lex.sv
sv/source_text_tokenizer.sv
sv/stt_chk.sv
tb/source_text_tokenizer_tb.sv
